### rtl/vtpg_pkg.sv
// -----------------------------------------------------------------------------
// vtpg_pkg: shared definitions for the video test pattern generator
// Pattern codes, colour constants and the BGR555 packing helper.
// -----------------------------------------------------------------------------
package vtpg_pkg;

   localparam int COORD_W  = 8;
   localparam int CHAN_W   = 5;
   localparam int COLOUR_W = 3 * CHAN_W;

   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [COLOUR_W-1:0] colour_type;
   typedef logic [1:0]          pattern_type;

   localparam pattern_type PAT_BARS    = 2'd0;
   localparam pattern_type PAT_HATCH   = 2'd1;
   localparam pattern_type PAT_SWEEP   = 2'd2;
   localparam pattern_type PAT_CHECKER = 2'd3;

   // Rows above this line show the bars in the bar pattern
   localparam coord_type BAR_ROWS = 8'd128;

   localparam chan_type CHAN_FULL = 5'd31;
   localparam chan_type CHAN_ZERO = 5'd0;
   localparam chan_type HATCH_BG_BLUE = 5'd6;

   function automatic colour_type pack555(chan_type red, chan_type green, chan_type blue);
      return {blue, green, red};
   endfunction

   localparam colour_type COLOUR_WHITE = {CHAN_FULL, CHAN_FULL, CHAN_FULL};
   localparam colour_type COLOUR_BLACK = {CHAN_ZERO, CHAN_ZERO, CHAN_ZERO};
   localparam colour_type COLOUR_HATCH_BG = {HATCH_BG_BLUE, CHAN_ZERO, CHAN_ZERO};

endpackage

### rtl/vtpg_pixel.sv
// -----------------------------------------------------------------------------
// vtpg_pixel: pixel colour logic
// Combinational colour of one pixel from its column, row and frame bits.
// -----------------------------------------------------------------------------
module vtpg_pixel (
   input  vtpg_pkg::coord_type  column,
   input  vtpg_pkg::coord_type  line_row,
   input  vtpg_pkg::coord_type  frame_count,
   output vtpg_pkg::colour_type colour
);

   vtpg_pkg::pattern_type pattern;
   vtpg_pkg::chan_type    level;
   vtpg_pkg::coord_type   col_sum;
   vtpg_pkg::coord_type   row_sum;
   logic [2:0]            bar;
   logic                  hline;
   logic                  vline;
   logic                  checker_on;
   vtpg_pkg::colour_type  grey;

   assign pattern = frame_count[6:5];
   assign level   = column[7:3];
   assign grey    = vtpg_pkg::pack555(level, level, level);

   // Sums wrap at eight bits; bars use col_sum[7:5], lines use bits 4:1
   assign col_sum = column + frame_count;
   assign row_sum = line_row + {1'b0, frame_count[7:1]};

   assign bar        = col_sum[7:5];
   assign vline      = (col_sum[4:1] == 4'd0);
   assign hline      = (row_sum[4:1] == 4'd0);
   assign checker_on = column[3] ^ line_row[3] ^ frame_count[4];

   always_comb begin
      unique case (pattern)
         vtpg_pkg::PAT_BARS: begin
            if (line_row < vtpg_pkg::BAR_ROWS) begin
               colour = vtpg_pkg::pack555(bar[2] ? vtpg_pkg::CHAN_ZERO : vtpg_pkg::CHAN_FULL,
                                          bar[1] ? vtpg_pkg::CHAN_ZERO : vtpg_pkg::CHAN_FULL,
                                          bar[0] ? vtpg_pkg::CHAN_ZERO : vtpg_pkg::CHAN_FULL);
            end else begin
               colour = grey;
            end
         end
         vtpg_pkg::PAT_HATCH: begin
            colour = (hline || vline) ? vtpg_pkg::COLOUR_WHITE : vtpg_pkg::COLOUR_HATCH_BG;
         end
         vtpg_pkg::PAT_SWEEP: begin
            if (column > frame_count) begin
               colour = grey;
            end else begin
               colour = vtpg_pkg::pack555(vtpg_pkg::CHAN_FULL - level,
                                          vtpg_pkg::CHAN_ZERO, level);
            end
         end
         vtpg_pkg::PAT_CHECKER: begin
            colour = checker_on ? vtpg_pkg::COLOUR_WHITE : vtpg_pkg::COLOUR_BLACK;
         end
         default: begin
            colour = vtpg_pkg::COLOUR_BLACK;
         end
      endcase
   end

endmodule

### rtl/video_test_pattern_generator.sv
// -----------------------------------------------------------------------------
// video_test_pattern_generator: animated BGR555 test patterns
// Colour of one pixel per transfer, four patterns picked by the frame count.
// -----------------------------------------------------------------------------
// Usage:
//   Present a pixel's column, row and low frame-count bits on req_* with
//   start high. A transfer takes place at each rising edge where start is
//   high and busy is low; busy never rises, so one pixel is taken every
//   cycle.
//   The colour appears on rsp_colour once the pixel has passed the input
//   register, the colour logic and the output register, with rsp_valid
//   high for a single cycle for it; throughput is one pixel per cycle.
//   The receiver cannot stall: every result must be taken in its cycle.
//   A synchronous reset drops all pixels in flight and clears rsp_valid.
//   Off-screen coordinates are not rejected; they follow the same formulas.
// -----------------------------------------------------------------------------
module video_test_pattern_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vtpg_pkg::coord_type  req_column,
   input  vtpg_pkg::coord_type  req_line_row,
   input  vtpg_pkg::coord_type  req_frame_count,
   output logic                 rsp_valid,
   output vtpg_pkg::colour_type rsp_colour
);

   logic                 valid_ff;
   logic                 valid_in;
   vtpg_pkg::coord_type  col_ff;
   vtpg_pkg::coord_type  row_ff;
   vtpg_pkg::coord_type  frm_ff;
   logic                 out_valid_ff;
   vtpg_pkg::colour_type out_colour_ff;
   vtpg_pkg::colour_type out_colour_in;

   assign busy     = 1'b0;
   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff;
      end
   end

   // Payload registers: hold only what a transfer brings in
   always_ff @(posedge clock) begin
      if (valid_in) begin
         col_ff <= req_column;
         row_ff <= req_line_row;
         frm_ff <= req_frame_count;
      end
      if (valid_ff) begin
         out_colour_ff <= out_colour_in;
      end
   end

   vtpg_pixel u_pixel (
      .column      (col_ff),
      .line_row    (row_ff),
      .frame_count (frm_ff),
      .colour      (out_colour_in)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_colour = out_colour_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid)
      else $error("accepted pixel did not produce a result two cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without a matching transfer");

   a_checker_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(frm_ff[6:5]) == vtpg_pkg::PAT_CHECKER) |->
         (rsp_colour == vtpg_pkg::COLOUR_WHITE || rsp_colour == vtpg_pkg::COLOUR_BLACK))
      else $error("checkerboard pixel is neither black nor white");

   a_hatch_colours: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(frm_ff[6:5]) == vtpg_pkg::PAT_HATCH) |->
         (rsp_colour == vtpg_pkg::COLOUR_WHITE || rsp_colour == vtpg_pkg::COLOUR_HATCH_BG))
      else $error("crosshatch pixel has an unexpected colour");

endmodule

### dv/tb_video_test_pattern_generator.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_video_test_pattern_generator: self-checking bench for the pattern source
// Feeds pixels (column, row, frame) through the start/busy handshake, predicts
// each BGR555 colour for all four patterns and checks every strobed result in
// order. Directed corner pixels come first, then random pixels on and off
// screen under three sender idling profiles.
// -----------------------------------------------------------------------------
module tb_video_test_pattern_generator;

   localparam int RANDOM_PIXELS  = 1100;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 6;

   typedef struct packed {
      vtpg_pkg::coord_type column;
      vtpg_pkg::coord_type line_row;
      vtpg_pkg::coord_type frame_count;
   } pixel_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   vtpg_pkg::coord_type  req_column = '0;
   vtpg_pkg::coord_type  req_line_row = '0;
   vtpg_pkg::coord_type  req_frame_count = '0;
   logic                 rsp_valid;
   vtpg_pkg::colour_type rsp_colour;

   pixel_req_type        pending_pixels[$];
   vtpg_pkg::colour_type expected_colours[$];
   int                   pixel_total = 0;
   int                   pixels_sent = 0;
   int                   stall_cycles = 0;
   bit                   failed = 1'b0;

   video_test_pattern_generator uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_column      (req_column),
      .req_line_row    (req_line_row),
      .req_frame_count (req_frame_count),
      .rsp_valid       (rsp_valid),
      .rsp_colour      (rsp_colour)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic vtpg_pkg::colour_type pixel_colour(vtpg_pkg::coord_type col,
                                                         vtpg_pkg::coord_type row,
                                                         vtpg_pkg::coord_type frm);
      vtpg_pkg::chan_type   level;
      vtpg_pkg::chan_type   grey_inv;
      logic [8:0]           col_sum;
      vtpg_pkg::coord_type  row_sum;
      logic [2:0]           bar;
      logic                 hline;
      logic                 vline;
      vtpg_pkg::colour_type grey;
      vtpg_pkg::colour_type white;
      level    = col[7:3];
      grey_inv = 5'd31 - level;
      col_sum  = {1'b0, col} + {1'b0, frm};
      row_sum  = row + {1'b0, frm[7:1]};
      bar      = col_sum[7:5];
      grey     = {level, level, level};
      white    = {5'd31, 5'd31, 5'd31};
      case (vtpg_pkg::pattern_type'(frm[6:5]))
         vtpg_pkg::PAT_BARS: begin
            if (row < vtpg_pkg::BAR_ROWS)
               return {bar[0] ? 5'd0 : 5'd31, bar[1] ? 5'd0 : 5'd31, bar[2] ? 5'd0 : 5'd31};
            return grey;
         end
         vtpg_pkg::PAT_HATCH: begin
            hline = row_sum[4:0] < 5'd2;
            vline = col_sum[4:0] < 5'd2;
            return (hline || vline) ? white : {5'd6, 5'd0, 5'd0};
         end
         vtpg_pkg::PAT_SWEEP: begin
            if (col > frm)
               return grey;
            return {level, 5'd0, grey_inv};
         end
         default: begin
            // cell parity against row-band parity advanced every 16 frames
            return (col[3] ^ row[3] ^ frm[4]) ? white : 15'd0;
         end
      endcase
   endfunction

   task automatic add_pixel(int col, int row, int frm);
      pixel_req_type item;
      item.column      = vtpg_pkg::coord_type'(col);
      item.line_row    = vtpg_pkg::coord_type'(row);
      item.frame_count = vtpg_pkg::coord_type'(frm);
      pending_pixels.push_back(item);
   endtask

   // Driver: record the transfer just taken, then present the next pixel or idle
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_colours.push_back(pixel_colour(req_column, req_line_row, req_frame_count));
            pixels_sent++;
         end
         if (start && busy) begin
            // hold the current pixel until taken
         end else begin
            if (pixels_sent < pixel_total / 3)
               idle_pct = 11;
            else if (pixels_sent < 2 * pixel_total / 3)
               idle_pct = 75;
            else
               idle_pct = 0;
            if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
               pixel_req_type item;
               item = pending_pixels.pop_front();
               req_column      <= item.column;
               req_line_row    <= item.line_row;
               req_frame_count <= item.frame_count;
               start           <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed colour must match the oldest prediction
   always @(posedge clock) begin
      vtpg_pkg::colour_type want;
      if (!reset && rsp_valid) begin
         if (expected_colours.size() == 0) begin
            $error("rsp_colour: unexpected result %h", rsp_colour);
            failed = 1'b1;
         end else begin
            want = expected_colours.pop_front();
            if (rsp_colour !== want) begin
               $error("rsp_colour mismatch: expected %h actual %h", want, rsp_colour);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_video_test_pattern_generator NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int mode;
      // bars: corner, last bar row, first ramp row, bar wrap past 255
      add_pixel(0, 0, 0);
      add_pixel(239, 127, 0);
      add_pixel(127, 128, 0);
      add_pixel(128, 127, 31);
      add_pixel(239, 159, 31);
      add_pixel(239, 10, 31);
      // off-screen column and row
      add_pixel(240, 160, 0);
      add_pixel(255, 255, 31);
      // crosshatch: vertical line, horizontal line, background
      add_pixel(0, 0, 32);
      add_pixel(31, 50, 34);
      add_pixel(100, 14, 36);
      add_pixel(5, 5, 40);
      add_pixel(255, 255, 63);
      // edge sweep: column equal to frame, just right of it, extremes
      add_pixel(64, 10, 64);
      add_pixel(65, 10, 64);
      add_pixel(0, 0, 95);
      add_pixel(255, 159, 95);
      // checkerboard: cell and band flips, frame phase flip
      add_pixel(0, 0, 96);
      add_pixel(8, 0, 96);
      add_pixel(0, 8, 96);
      add_pixel(0, 0, 112);
      add_pixel(7, 7, 127);
      add_pixel(255, 255, 255);
      add_pixel(200, 100, 100);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         mode = $urandom_range(9);
         if (mode < 7)
            add_pixel($urandom_range(239), $urandom_range(159), $urandom_range(255));
         else
            add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
      pixel_total = pending_pixels.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() != 0 || start || expected_colours.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed)
         $display("tb_video_test_pattern_generator OK");
      else
         $display("tb_video_test_pattern_generator NOT OK");
      $finish;
   end

endmodule

### filelist.f
rtl/vtpg_pkg.sv
rtl/vtpg_pixel.sv
rtl/video_test_pattern_generator.sv
dv/tb_video_test_pattern_generator.sv
